// ===== design/frame_deadline_pacer_with_debt_recovery_core_macros.svh =====
// assertion helpers for the frame deadline pacer
`ifndef FRAME_DEADLINE_PACER_WITH_DEBT_RECOVERY_CORE_MACROS_SVH
`define FRAME_DEADLINE_PACER_WITH_DEBT_RECOVERY_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define FDP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define FDP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fdp_pkg.sv =====
package fdp_pkg;

  // default field widths
  localparam int unsigned TimeBits     = 48;
  localparam int unsigned IntervalBits = 32;
  // repayment interval counter width
  localparam int unsigned IvlLeftBits  = 32;
  // configuration register index width
  localparam int unsigned CfgIdxBits   = 1;

  // configuration register map
  typedef enum logic [CfgIdxBits-1:0] {
    REG_FRAME_INTERVAL  = 1'b0,
    REG_RECOVERY_WINDOW = 1'b1
  } reg_idx_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_MEAS,
    OP_PHASE,
    OP_TARGET,
    OP_DEBT,
    OP_DIV_N,
    OP_SET_N,
    OP_DIV_D,
    OP_APPLY,
    OP_STEP,
    OP_DEADLINE,
    OP_COMMIT
  } dp_op_e;

  // datapath flags seen by the controller
  typedef struct packed {
    logic rec_on;
    logic late_nz;
    logic ivl_zero;
    logic debt_nz;
    logic div_done;
  } dp_status_t;

endpackage

// ===== design/frame_deadline_pacer_with_debt_recovery_core.sv =====
// Frame deadline pacer with lateness debt recovery.
// Input channel (in_valid_i/in_ready_o): cmd_i = 0 reports a frame start at
// start_time_i, cmd_i = 1 clears all pacing state. Every transaction yields
// exactly one result on the output channel (out_valid_o/out_ready_i).
// Configuration: cfg_we_i writes cfg_data_i into frame_interval (index 0) or
// recovery_window (index 1); write only while no transaction is in flight.
// Sequencing: one transaction at a time, as in_ready_o is high only while idle;
// the result becomes valid in the same cycle that the input is ready again. A
// clear command passes through a clear step and the output step. A frame start
// steps through measure, phase, target, debt and schedule; with recovery on it
// may divide the window by the interval, and the debt by the intervals left,
// before the step, deadline and output steps. The bit-serial divider makes one
// quotient bit per cycle over INTERVAL_BITS + 1 bits.
// The result sits in its own register, so in_ready_o rises again as soon as it
// is loaded, and the next transaction is worked on while the receiver stalls;
// that one waits in its last step until the result register is free.
// Reset clears the configuration registers, the pacing state and the result valid.
`include "frame_deadline_pacer_with_debt_recovery_core_macros.svh"

module frame_deadline_pacer_with_debt_recovery_core #(
  parameter int unsigned TIME_BITS     = fdp_pkg::TimeBits,
  parameter int unsigned INTERVAL_BITS = fdp_pkg::IntervalBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fdp_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [INTERVAL_BITS-1:0]       cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [TIME_BITS-1:0]           start_time_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [TIME_BITS-1:0]           next_deadline_o,
  output logic [INTERVAL_BITS:0]         recovery_debt_o,
  output logic                           recovery_limited_o,
  output logic                           has_previous_o,
  output logic signed [TIME_BITS-1:0]    measured_interval_o,
  output logic [TIME_BITS-1:0]           target_interval_o,
  output logic signed [TIME_BITS-1:0]    phase_error_o
);

  fdp_pkg::dp_op_e     op;
  fdp_pkg::dp_status_t status;
  logic                out_no_prev;
  logic                timing_zero;
  logic                debt_flagged;
  logic                in_accept;

  // sequencer
  fdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (cmd_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .op_o        (op)
  );

  // arithmetic and state
  fdp_dp #(
    .TIME_BITS     (TIME_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .op_i                (op),
    .status_o            (status),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .start_time_i        (start_time_i),
    .next_deadline_o     (next_deadline_o),
    .recovery_debt_o     (recovery_debt_o),
    .recovery_limited_o  (recovery_limited_o),
    .has_previous_o      (has_previous_o),
    .measured_interval_o (measured_interval_o),
    .target_interval_o   (target_interval_o),
    .phase_error_o       (phase_error_o)
  );

  // terms for the checks
  assign out_no_prev  = out_valid_o && !has_previous_o;
  assign timing_zero  = (measured_interval_o == '0) && (target_interval_o == '0) &&
                        (phase_error_o == '0);
  assign debt_flagged = out_valid_o && ((recovery_debt_o != '0) || recovery_limited_o);
  assign in_accept    = in_valid_i && in_ready_o;

  // checks
  `FDP_ASSERT_IMP(a_no_prev_zero, out_no_prev, timing_zero, "timing set without previous start")
  `FDP_ASSERT_IMP(a_debt_needs_prev, debt_flagged, has_previous_o, "debt without previous start")
  `FDP_ASSERT_NXT(a_busy_after_accept, in_accept, !in_ready_o, "input accepted while busy")

endmodule

// ===== design/fdp_div.sv =====
module fdp_div #(
  parameter int unsigned NUM_BITS = 33,
  parameter int unsigned DEN_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  output logic                done_o,
  output logic [NUM_BITS-1:0] quo_o,
  output logic                rem_nz_o
);

  localparam int unsigned CntBits = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] quo_q;
  logic [DEN_BITS-1:0] rem_q;
  logic [DEN_BITS-1:0] den_q;
  logic [CntBits-1:0]  cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // one restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    trial = {rem_q, quo_q[NUM_BITS-1]};
    diff  = trial - {1'b0, den_q};
    fits  = ~diff[DEN_BITS];
  end

  // step counter and completion flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntBits'(NUM_BITS);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      quo_q <= {quo_q[NUM_BITS-2:0], fits};
    end
  end

  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

// ===== design/fdp_dp.sv =====
module fdp_dp #(
  parameter int unsigned TIME_BITS     = fdp_pkg::TimeBits,
  parameter int unsigned INTERVAL_BITS = fdp_pkg::IntervalBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fdp_pkg::dp_op_e                   op_i,
  output fdp_pkg::dp_status_t               status_o,
  input  logic                              cfg_we_i,
  input  logic [fdp_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [INTERVAL_BITS-1:0]          cfg_data_i,
  input  logic [TIME_BITS-1:0]              start_time_i,
  output logic [TIME_BITS-1:0]              next_deadline_o,
  output logic [INTERVAL_BITS:0]            recovery_debt_o,
  output logic                              recovery_limited_o,
  output logic                              has_previous_o,
  output logic signed [TIME_BITS-1:0]       measured_interval_o,
  output logic [TIME_BITS-1:0]              target_interval_o,
  output logic signed [TIME_BITS-1:0]       phase_error_o
);

  localparam int unsigned IvlBits  = fdp_pkg::IvlLeftBits;
  localparam int unsigned DebtBits = INTERVAL_BITS + 1;
  localparam int unsigned DenBits  = (INTERVAL_BITS > IvlBits) ? INTERVAL_BITS : IvlBits;
  localparam int unsigned SumBits  = ((TIME_BITS > DebtBits) ? TIME_BITS : DebtBits) + 1;
  localparam int unsigned DlBits   =
      ((TIME_BITS > INTERVAL_BITS) ? TIME_BITS : INTERVAL_BITS) + 1;
  localparam int unsigned WideBits = (DebtBits > IvlBits) ? DebtBits : IvlBits;

  // configuration and pacing state
  logic [INTERVAL_BITS-1:0] fi_q, rw_q;
  logic [TIME_BITS-1:0]     deadline_q, last_start_q;
  logic [DebtBits-1:0]      debt_q;
  logic [IvlBits-1:0]       ivl_left_q;
  logic                     seen_q;

  // per-transaction working registers
  logic [TIME_BITS-1:0]     start_q, meas_q, phase_q, target_q, late_q;
  logic                     had_prev_q, limited_q, rec_on_q;
  logic [INTERVAL_BITS-1:0] applied_q, step_q;

  // result registers
  logic [TIME_BITS-1:0]     nd_out_q, meas_out_q, target_out_q, phase_out_q;
  logic [DebtBits-1:0]      debt_out_q;
  logic                     limited_out_q, prev_out_q;

  // shared divider
  logic                     div_start, div_done, div_rem_nz;
  logic [DebtBits-1:0]      div_num, div_quo;
  logic [DenBits-1:0]       div_den;

  // combinational helpers
  logic [TIME_BITS:0]       diff_ms, diff_pd, diff_tg;
  logic [SumBits-1:0]       debt_sum;
  logic [DebtBits-1:0]      max_debt;
  logic                     debt_over;
  logic [DebtBits-1:0]      n_val;
  logic [WideBits-1:0]      n_wide;
  logic [IvlBits-1:0]       ivl_new;
  logic [INTERVAL_BITS-1:0] cap;
  logic                     desired_gt;
  logic [INTERVAL_BITS-1:0] applied_new;
  logic [INTERVAL_BITS-1:0] step_new;
  logic [DlBits-1:0]        dl_sum;
  logic [TIME_BITS-1:0]     time_max;
  logic [TIME_BITS-1:0]     dl_new;

  // a - b saturated to the signed time range
  function automatic logic [TIME_BITS-1:0] sat_diff(input logic [TIME_BITS:0] d);
    logic [TIME_BITS-1:0] r;
    if (!d[TIME_BITS] && d[TIME_BITS-1]) begin
      r = {1'b0, {(TIME_BITS-1){1'b1}}};
    end else if (d[TIME_BITS] && !d[TIME_BITS-1]) begin
      r = {1'b1, {(TIME_BITS-1){1'b0}}};
    end else begin
      r = d[TIME_BITS-1:0];
    end
    return r;
  endfunction

  // divider operand select: window over interval, or debt over intervals left
  assign div_start = (op_i == fdp_pkg::OP_DIV_N) || (op_i == fdp_pkg::OP_DIV_D);
  assign div_num   = (op_i == fdp_pkg::OP_DIV_N) ? {1'b0, rw_q} : debt_q;
  assign div_den   = (op_i == fdp_pkg::OP_DIV_N) ? DenBits'(fi_q) : DenBits'(ivl_left_q);

  fdp_div #(
    .NUM_BITS (DebtBits),
    .DEN_BITS (DenBits)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .done_o   (div_done),
    .quo_o    (div_quo),
    .rem_nz_o (div_rem_nz)
  );

  // timing differences against the previous frame
  assign diff_ms = {1'b0, start_q} - {1'b0, last_start_q};
  assign diff_pd = {1'b0, start_q} - {1'b0, deadline_q};
  assign diff_tg = {1'b0, deadline_q} - {1'b0, last_start_q};

  // debt accumulation against the clamp of two intervals
  assign debt_sum  = SumBits'(debt_q) + SumBits'(late_q);
  assign max_debt  = {fi_q, 1'b0};
  assign debt_over = debt_sum > SumBits'(max_debt);

  // ceiling of the quotient, at least one interval
  assign n_val   = div_quo + DebtBits'(div_rem_nz);
  assign n_wide  = WideBits'(n_val);
  assign ivl_new = (n_val == '0) ? IvlBits'(1) : n_wide[IvlBits-1:0];

  // per-frame repayment capped at a quarter interval
  assign cap         = fi_q >> 2;
  assign desired_gt  = div_quo > DebtBits'(cap);
  assign applied_new = desired_gt ? cap : div_quo[INTERVAL_BITS-1:0];

  // shortened step and saturating deadline
  assign step_new = (fi_q > applied_q) ? (fi_q - applied_q) : '0;
  assign dl_sum   = DlBits'(start_q) + DlBits'(step_q);
  assign time_max = '1;
  assign dl_new   = (dl_sum > DlBits'(time_max)) ? time_max : dl_sum[TIME_BITS-1:0];

  // configuration registers and pacing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q         <= '0;
      rw_q         <= '0;
      deadline_q   <= '0;
      last_start_q <= '0;
      debt_q       <= '0;
      ivl_left_q   <= '0;
      seen_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fdp_pkg::REG_FRAME_INTERVAL:  fi_q <= cfg_data_i;
          fdp_pkg::REG_RECOVERY_WINDOW: rw_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (op_i)
        fdp_pkg::OP_CLEAR: begin
          deadline_q   <= '0;
          last_start_q <= '0;
          debt_q       <= '0;
          ivl_left_q   <= '0;
          seen_q       <= 1'b0;
        end
        fdp_pkg::OP_DEBT: begin
          if (!rec_on_q) begin
            debt_q     <= '0;
            ivl_left_q <= '0;
          end else if (debt_over) begin
            debt_q <= max_debt;
          end else begin
            debt_q <= debt_sum[DebtBits-1:0];
          end
        end
        fdp_pkg::OP_SET_N: ivl_left_q <= ivl_new;
        fdp_pkg::OP_APPLY: begin
          debt_q     <= debt_q - DebtBits'(applied_new);
          ivl_left_q <= ivl_left_q - 1'b1;
        end
        fdp_pkg::OP_DEADLINE: begin
          deadline_q   <= dl_new;
          last_start_q <= start_q;
          seen_q       <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers and result registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      fdp_pkg::OP_LOAD: start_q <= start_time_i;
      fdp_pkg::OP_CLEAR: begin
        had_prev_q <= 1'b0;
        meas_q     <= '0;
        phase_q    <= '0;
        target_q   <= '0;
        limited_q  <= 1'b0;
      end
      fdp_pkg::OP_MEAS: begin
        had_prev_q <= seen_q;
        meas_q     <= seen_q ? sat_diff(diff_ms) : '0;
      end
      fdp_pkg::OP_PHASE: begin
        phase_q <= seen_q ? sat_diff(diff_pd) : '0;
        late_q  <= diff_pd[TIME_BITS] ? '0 : diff_pd[TIME_BITS-1:0];
      end
      fdp_pkg::OP_TARGET: begin
        target_q  <= (seen_q && !diff_tg[TIME_BITS]) ? diff_tg[TIME_BITS-1:0] : '0;
        rec_on_q  <= (deadline_q != '0) && (fi_q != '0) && (rw_q != '0);
        limited_q <= 1'b0;
        applied_q <= '0;
      end
      fdp_pkg::OP_DEBT: limited_q <= rec_on_q && debt_over;
      fdp_pkg::OP_APPLY: begin
        applied_q <= applied_new;
        if (desired_gt) begin
          limited_q <= 1'b1;
        end
      end
      fdp_pkg::OP_STEP: step_q <= step_new;
      fdp_pkg::OP_COMMIT: begin
        nd_out_q      <= deadline_q;
        debt_out_q    <= debt_q;
        limited_out_q <= limited_q;
        prev_out_q    <= had_prev_q;
        meas_out_q    <= meas_q;
        target_out_q  <= target_q;
        phase_out_q   <= phase_q;
      end
      default: ;
    endcase
  end

  // status for the controller
  assign status_o.rec_on   = rec_on_q;
  assign status_o.late_nz  = |late_q;
  assign status_o.ivl_zero = (ivl_left_q == '0);
  assign status_o.debt_nz  = |debt_q;
  assign status_o.div_done = div_done;

  assign next_deadline_o     = nd_out_q;
  assign recovery_debt_o     = debt_out_q;
  assign recovery_limited_o  = limited_out_q;
  assign has_previous_o      = prev_out_q;
  assign measured_interval_o = meas_out_q;
  assign target_interval_o   = target_out_q;
  assign phase_error_o       = phase_out_q;

endmodule

// ===== design/fdp_ctrl.sv =====
module fdp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_cmd_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  fdp_pkg::dp_status_t status_i,
  output fdp_pkg::dp_op_e     op_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_MEAS,
    S_PHASE,
    S_TARGET,
    S_DEBT,
    S_SCHED,
    S_NWAIT,
    S_REPAY,
    S_DWAIT,
    S_STEP,
    S_DL,
    S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // operation decode per state
  always_comb begin
    op_o = fdp_pkg::OP_NONE;
    case (state_q)
      S_IDLE:   if (in_valid_i) op_o = fdp_pkg::OP_LOAD;
      S_CLR:    op_o = fdp_pkg::OP_CLEAR;
      S_MEAS:   op_o = fdp_pkg::OP_MEAS;
      S_PHASE:  op_o = fdp_pkg::OP_PHASE;
      S_TARGET: op_o = fdp_pkg::OP_TARGET;
      S_DEBT:   op_o = fdp_pkg::OP_DEBT;
      S_SCHED: begin
        if (status_i.rec_on && (status_i.late_nz || status_i.ivl_zero)) begin
          op_o = fdp_pkg::OP_DIV_N;
        end
      end
      S_NWAIT:  if (status_i.div_done) op_o = fdp_pkg::OP_SET_N;
      S_REPAY:  if (status_i.debt_nz) op_o = fdp_pkg::OP_DIV_D;
      S_DWAIT:  if (status_i.div_done) op_o = fdp_pkg::OP_APPLY;
      S_STEP:   op_o = fdp_pkg::OP_STEP;
      S_DL:     op_o = fdp_pkg::OP_DEADLINE;
      S_OUT:    if (out_free) op_o = fdp_pkg::OP_COMMIT;
      default:  op_o = fdp_pkg::OP_NONE;
    endcase
  end

  // sequencer and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // result valid: set on commit, dropped once the result is taken
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= in_cmd_i ? S_CLR : S_MEAS;
          end
        end
        S_CLR:    state_q <= S_OUT;
        S_MEAS:   state_q <= S_PHASE;
        S_PHASE:  state_q <= S_TARGET;
        S_TARGET: state_q <= S_DEBT;
        S_DEBT:   state_q <= S_SCHED;
        S_SCHED: begin
          if (!status_i.rec_on) begin
            state_q <= S_STEP;
          end else if (status_i.late_nz || status_i.ivl_zero) begin
            state_q <= S_NWAIT;
          end else begin
            state_q <= S_REPAY;
          end
        end
        S_NWAIT:  if (status_i.div_done) state_q <= S_REPAY;
        S_REPAY:  state_q <= status_i.debt_nz ? S_DWAIT : S_STEP;
        S_DWAIT:  if (status_i.div_done) state_q <= S_STEP;
        S_STEP:   state_q <= S_DL;
        S_DL:     state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== bench/tb_frame_deadline_pacer_with_debt_recovery_core.sv =====
`timescale 1ns / 100ps

module tb_frame_deadline_pacer_with_debt_recovery_core;

  localparam int unsigned TB = fdp_pkg::TimeBits;
  localparam int unsigned IB = fdp_pkg::IntervalBits;
  localparam logic [63:0] TIME_MAX = (64'd1 << TB) - 64'd1;
  localparam logic [63:0] SIGNED_MAX = TIME_MAX >> 1;
  localparam logic [63:0] WORD_MAX = (64'd1 << IB) - 64'd1;
  // longest frame start, with some margin
  localparam int unsigned SETTLE_CYCLES = 2 * (IB + 2) + 30;

  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_CLEAR = 1'b1
  } pace_cmd_e;

  typedef struct packed {
    logic [TB-1:0] next_deadline;
    logic [IB:0]   recovery_debt;
    logic          recovery_limited;
    logic          has_previous;
    logic [TB-1:0] measured_interval;
    logic [TB-1:0] target_interval;
    logic [TB-1:0] phase_error;
  } pace_result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [fdp_pkg::CfgIdxBits-1:0] cfg_idx_i;
  logic [IB-1:0]                  cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           cmd_i;
  logic [TB-1:0]                  start_time_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [TB-1:0]                  next_deadline_o;
  logic [IB:0]                    recovery_debt_o;
  logic                           recovery_limited_o;
  logic                           has_previous_o;
  logic signed [TB-1:0]           measured_interval_o;
  logic [TB-1:0]                  target_interval_o;
  logic signed [TB-1:0]           phase_error_o;

  frame_deadline_pacer_with_debt_recovery_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .start_time_i       (start_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .next_deadline_o    (next_deadline_o),
    .recovery_debt_o    (recovery_debt_o),
    .recovery_limited_o (recovery_limited_o),
    .has_previous_o     (has_previous_o),
    .measured_interval_o(measured_interval_o),
    .target_interval_o  (target_interval_o),
    .phase_error_o      (phase_error_o)
  );

  // pacing state tracked on the bench side
  logic [TB-1:0] trk_deadline;
  logic [IB:0]   trk_debt;
  logic [31:0]   trk_left;
  logic [TB-1:0] trk_last_start;
  logic          trk_seen;
  logic [IB-1:0] set_interval;
  logic [IB-1:0] set_window;

  pace_result_t  expected_paces[$];
  int unsigned   mismatch_count;
  int unsigned   gap_pct;
  int unsigned   stall_pct;
  int unsigned   ready_hold_cycles;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // a - b as a TB-bit two's complement pattern, saturating
  function automatic logic [TB-1:0] signed_gap(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    if (a >= b) begin
      d = a - b;
      if (d > SIGNED_MAX) d = SIGNED_MAX;
    end else begin
      d = b - a;
      if (d > SIGNED_MAX + 64'd1) d = SIGNED_MAX + 64'd1;
      d = 64'd0 - d;
    end
    return d[TB-1:0];
  endfunction

  function automatic void clear_pacing();
    trk_deadline   = '0;
    trk_debt       = '0;
    trk_left       = '0;
    trk_last_start = '0;
    trk_seen       = 1'b0;
  endfunction

  // advance the tracked pacing state by one transaction, return its result
  function automatic pace_result_t pace_frame(pace_cmd_e cmd, logic [TB-1:0] start);
    pace_result_t r;
    logic [63:0]  prev_dl, late, max_debt, n, desired, cap, applied, step, room;
    logic [63:0]  debt, ivl, win;
    logic         limited;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      clear_pacing();
      return r;
    end
    prev_dl = trk_deadline;
    ivl     = set_interval;
    win     = set_window;
    debt    = trk_debt;
    applied = 0;
    limited = 1'b0;
    r.has_previous = trk_seen;
    if (trk_seen) begin
      r.measured_interval = signed_gap(start, trk_last_start);
      r.target_interval   = (trk_deadline > trk_last_start) ?
                            trk_deadline - trk_last_start : '0;
      r.phase_error       = signed_gap(start, trk_deadline);
    end
    trk_last_start = start;
    trk_seen       = 1'b1;

    if (prev_dl != 0 && ivl != 0 && win != 0) begin
      // lateness goes into the debt, clamped to two intervals
      late     = (start > prev_dl) ? start - prev_dl : 64'd0;
      max_debt = ivl * 2;
      if (debt > max_debt || late > max_debt - debt) begin
        debt    = max_debt;
        limited = 1'b1;
      end else begin
        debt = debt + late;
      end
      // restart the repayment schedule
      if (late != 0 || trk_left == 0) begin
        n = win / ivl + ((win % ivl != 0) ? 64'd1 : 64'd0);
        trk_left = (n < 1) ? 32'd1 : n[31:0];
      end
      // repay a share, at most a quarter interval
      if (debt != 0) begin
        desired = debt / trk_left;
        cap     = ivl / 4;
        applied = (desired < cap) ? desired : cap;
        if (desired > cap) limited = 1'b1;
        debt     = debt - applied;
        trk_left = trk_left - 32'd1;
      end
      trk_debt = debt[IB:0];
    end else begin
      trk_debt = '0;
      trk_left = '0;
    end

    step = (ivl > applied) ? ivl - applied : 64'd0;
    room = TIME_MAX - start;
    trk_deadline = (step > room) ? TIME_MAX[TB-1:0] : start + step[TB-1:0];

    r.next_deadline    = trk_deadline;
    r.recovery_debt    = trk_debt;
    r.recovery_limited = limited;
    return r;
  endfunction

  function automatic logic [63:0] rand_upto(logic [63:0] n);
    if (n == 0) return 64'd0;
    return {$urandom, $urandom} % (n + 64'd1);
  endfunction

  function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  // frame starts clustered around the tracked deadline, with outliers
  function automatic logic [TB-1:0] pick_start();
    logic [63:0] base, span, t;
    int unsigned kind;
    base = trk_deadline;
    span = (set_interval != 0) ? set_interval : 64'd1000;
    kind = $urandom_range(99);
    if (kind < 35)      t = sat_sub(base, rand_upto(span / 2));
    else if (kind < 65) t = base + rand_upto(span / 2);
    else if (kind < 78) t = base + rand_upto(span * 4);
    else if (kind < 84) t = base + rand_upto(TIME_MAX);
    else if (kind < 89) t = sat_sub(trk_last_start, rand_upto(span));
    else if (kind < 94) t = rand_upto(TIME_MAX);
    else if (kind < 97) t = TIME_MAX - rand_upto(span * 2);
    else                t = rand_upto(span);
    if (t > TIME_MAX) t = TIME_MAX;
    return t[TB-1:0];
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin : result_check
    pace_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_paces.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_count++;
      end else begin
        want = expected_paces.pop_front();
        check_field("next_deadline", want.next_deadline, next_deadline_o);
        check_field("recovery_debt", want.recovery_debt, recovery_debt_o);
        check_field("recovery_limited", want.recovery_limited, recovery_limited_o);
        check_field("has_previous", want.has_previous, has_previous_o);
        check_field("measured_interval", want.measured_interval,
                    unsigned'(measured_interval_o));
        check_field("target_interval", want.target_interval, target_interval_o);
        check_field("phase_error", want.phase_error, unsigned'(phase_error_o));
      end
    end
  end

  // receiver: random stalls, plus a counted hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ready_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        ready_hold_cycles <= ready_hold_cycles - 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one input transaction, prediction recorded at acceptance
  task automatic send_event(pace_cmd_e cmd, logic [TB-1:0] stamp);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    start_time_i <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    expected_paces.push_back(pace_frame(cmd, stamp));
  endtask

  // stop sending and wait for every result and the core to go idle
  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_paces.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(fdp_pkg::reg_idx_e idx, logic [IB-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      fdp_pkg::REG_FRAME_INTERVAL:  set_interval = data;
      fdp_pkg::REG_RECOVERY_WINDOW: set_window   = data;
      default: ;
    endcase
  endtask

  task automatic set_pacing(logic [IB-1:0] ivl, logic [IB-1:0] win);
    quiesce();
    write_reg(fdp_pkg::REG_FRAME_INTERVAL, ivl);
    write_reg(fdp_pkg::REG_RECOVERY_WINDOW, win);
  endtask

  task automatic run_pacing(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3)
        send_event(CMD_CLEAR, rand_upto(TIME_MAX));
      else
        send_event(CMD_FRAME, pick_start());
    end
  endtask

  // extremes, saturation, clamp and cap, clear command
  task automatic test_directed();
    gap_pct   = 0;
    stall_pct = 0;
    // recovery off, wide jumps saturate the differences
    set_pacing('0, '0);
    send_event(CMD_FRAME, '0);
    send_event(CMD_FRAME, TIME_MAX[TB-1:0]);
    send_event(CMD_FRAME, '0);
    send_event(CMD_CLEAR, '0);
    // non-exact window ratio, on time, late, clamped, early, backwards
    set_pacing(32'd1000, 32'd3500);
    send_event(CMD_FRAME, 48'd10000);
    send_event(CMD_FRAME, 48'd11000);
    send_event(CMD_FRAME, 48'd12300);
    send_event(CMD_FRAME, 48'd20000);
    send_event(CMD_FRAME, 48'd20500);
    send_event(CMD_FRAME, 48'd5000);
    send_event(CMD_FRAME, TIME_MAX[TB-1:0]);
    send_event(CMD_FRAME, '0);
    send_event(CMD_CLEAR, TIME_MAX[TB-1:0]);
    send_event(CMD_FRAME, 48'd1000);
    // quarter interval floors to zero, so repayment is always capped
    set_pacing(32'd3, 32'd7);
    send_event(CMD_FRAME, 48'd100);
    send_event(CMD_FRAME, 48'd110);
    send_event(CMD_FRAME, 48'd112);
    // largest registers
    set_pacing(WORD_MAX[IB-1:0], WORD_MAX[IB-1:0]);
    send_event(CMD_FRAME, 48'd5);
    send_event(CMD_FRAME, 48'h7FFF_FFFF_FFFF);
    // very long repayment schedule
    set_pacing(32'd1, WORD_MAX[IB-1:0]);
    send_event(CMD_FRAME, 48'd50);
    send_event(CMD_FRAME, 48'd60);
  endtask

  task automatic test_no_idling();
    set_pacing(32'd1000, 32'd3500);
    gap_pct   = 0;
    stall_pct = 0;
    run_pacing(300);
  endtask

  task automatic test_sender_gaps();
    set_pacing(32'd997, 32'd10000);
    gap_pct   = 47;
    stall_pct = 0;
    run_pacing(300);
  endtask

  task automatic test_receiver_stalls();
    set_pacing(32'd40, 32'd100);
    gap_pct   = 0;
    stall_pct = 47;
    run_pacing(300);
  endtask

  task automatic test_both_idle();
    gap_pct   = 15;
    stall_pct = 15;
    set_pacing(WORD_MAX[IB-1:0], WORD_MAX[IB-1:0]);
    run_pacing(200);
    set_pacing(32'd1, WORD_MAX[IB-1:0]);
    run_pacing(120);
    set_pacing($urandom_range(1, 5000), $urandom);
    run_pacing(200);
  endtask

  // one of the two registers at zero, window below the interval, and a quarter interval that floors to zero
  task automatic test_recovery_off();
    gap_pct   = 15;
    stall_pct = 15;
    set_pacing('0, 32'd5000);
    run_pacing(80);
    set_pacing(32'd5000, '0);
    run_pacing(80);
    set_pacing(32'd1000, 32'd500);
    run_pacing(100);
    set_pacing(32'd3, 32'd7);
    run_pacing(100);
  endtask

  // receiver holds off long enough for the core to stall its input
  task automatic test_backpressure();
    set_pacing(32'd2000, 32'd9000);
    gap_pct   = 0;
    stall_pct = 0;
    ready_hold_cycles = 400;
    run_pacing(40);
    stall_pct = 30;
    run_pacing(100);
  endtask

  // sender waits once for every result midway, then goes on
  task automatic test_pause_drain();
    set_pacing(32'd500, 32'd1500);
    gap_pct   = 10;
    stall_pct = 10;
    run_pacing(60);
    quiesce();
    run_pacing(60);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = fdp_pkg::REG_FRAME_INTERVAL;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    cmd_i             = CMD_FRAME;
    start_time_i      = '0;
    out_ready_i       = 1'b0;
    mismatch_count    = 0;
    gap_pct           = 0;
    stall_pct         = 0;
    ready_hold_cycles = 0;
    set_interval      = '0;
    set_window        = '0;
    clear_pacing();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_recovery_off();
    test_backpressure();
    test_pause_drain();
    quiesce();

    if (mismatch_count == 0)
      $display("tb_frame_deadline_pacer_with_debt_recovery_core: PASS");
    else
      $display("tb_frame_deadline_pacer_with_debt_recovery_core: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("tb_frame_deadline_pacer_with_debt_recovery_core: FAIL");
    $finish;
  end

endmodule
